// File: hw/rtl/lj_pkg.sv
package lj_pkg;

    localparam int MAX_PARTICLES = 256;
    localparam int COORD_BITS    = 24;
    localparam int ADDR_BITS     = $clog2(MAX_PARTICLES);
    localparam int COUNT_BITS    = 9;
    localparam int BOX_BITS      = 23;
    localparam int CUT_BITS      = 32;
    localparam int ENERGY_BITS   = 48;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [1:0] FUNC_WRITE    = 2'd0;
    localparam logic [1:0] FUNC_PARTICLE = 2'd1;
    localparam logic [1:0] FUNC_TOTAL    = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUTOFF = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET  = 9'd1;
    localparam logic [BOX_BITS-1:0]   BOX_RESET    = 23'd65536;
    localparam logic [CUT_BITS-1:0]   CUTOFF_RESET = 32'd589824;

    localparam logic signed [ENERGY_BITS-1:0] E_MAX = {1'b0, {(ENERGY_BITS-1){1'b1}}};
    localparam logic signed [ENERGY_BITS-1:0] E_MIN = {1'b1, {(ENERGY_BITS-1){1'b0}}};

    localparam int DIV_BITS = 49;

endpackage

// File: hw/rtl/lj_particle_energy_unit.sv
// A write holds busy only through the done state; a query ends with its result beat after its pairs.
// A pair inside the cutoff runs the 49-bit divider and twelve 32x32 multiplies; a coincident pair
// saturates its term directly, a pair beyond the cutoff stops after the compare, a self index is skipped.
// Throughput: one item at a time; busy stays high until the result beat.
// The result beat is on energy and saturated for one cycle with done; the receiver cannot stall.
// Reset clears the sequencer and the registers to their reset values; the position store is not cleared.
module lj_particle_energy_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            func,
    input  logic [lj_pkg::ADDR_BITS-1:0]          particle_index,
    input  logic signed [lj_pkg::COORD_BITS-1:0]  pos_x,
    input  logic signed [lj_pkg::COORD_BITS-1:0]  pos_y,
    input  logic signed [lj_pkg::COORD_BITS-1:0]  pos_z,
    input  logic                                  cfg_we,
    input  logic [lj_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [lj_pkg::CUT_BITS-1:0]           cfg_data,
    output logic                                  done,
    output logic signed [lj_pkg::ENERGY_BITS-1:0] energy,
    output logic                                  saturated
);

    localparam int CB = lj_pkg::COORD_BITS;
    localparam int NB = lj_pkg::COUNT_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_NEXT, S_RDA, S_RDB, S_DIFF, S_SQ, S_CMP, S_DIV, S_MUL, S_TERM, S_ADD, S_DONE
    } state_t;

    state_t state_reg;

    logic [NB-1:0]                cnt_reg;
    logic [lj_pkg::BOX_BITS-1:0]  box_reg;
    logic [lj_pkg::CUT_BITS-1:0]  cut_reg;

    logic [3*CB-1:0]              pos_mem [lj_pkg::MAX_PARTICLES];
    logic [3*CB-1:0]              rdata_reg;
    logic [3*CB-1:0]              a_reg;
    logic [lj_pkg::ADDR_BITS-1:0] rd_addr;

    logic [1:0]                   func_reg;
    logic [NB-1:0]                i_reg;
    logic [NB-1:0]                j_reg;
    logic [NB-1:0]                n_lim;

    logic [25:0]                  dabs_reg [3];
    logic [53:0]                  sq_reg;
    logic [31:0]                  r2_reg;
    logic [2:0]                   step_reg;
    logic [1:0]                   phase_reg;

    logic [32:0]                  rem_reg;
    logic [lj_pkg::DIV_BITS-1:0]  quo_reg;
    logic [5:0]                   dcnt_reg;

    logic [63:0]                  s_reg;
    logic [63:0]                  s2_reg;
    logic [63:0]                  s3_reg;
    logic [63:0]                  s6_reg;
    logic [127:0]                 macc_reg;
    logic                         ov_reg;

    logic [31:0]                  mul_a;
    logic [31:0]                  mul_b;
    logic [63:0]                  mp_reg;

    logic signed [52:0]           term_reg;
    logic                         term_sat_reg;
    logic signed [lj_pkg::ENERGY_BITS-1:0] acc_reg;
    logic                         sat_reg;

    logic                         accept;
    logic signed [24:0]           dd [3];
    logic signed [26:0]           dfold [3];
    logic [26:0]                  dmag [3];
    logic [32:0]                  div_trial;
    logic [63:0]                  mx;
    logic [63:0]                  my;
    logic [127:0]                 pp_shift;
    logic [127:0]                 macc_sum;
    logic [37:0]                  r2_full;
    logic [63:0]                  pdiff;
    logic [64:0]                  ndiff;
    logic [49:0]                  tpos;
    logic [50:0]                  tneg;
    logic signed [53:0]           add_sum;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign n_lim  = (cnt_reg > NB'(lj_pkg::MAX_PARTICLES)) ? NB'(lj_pkg::MAX_PARTICLES) : cnt_reg;
    assign rd_addr = (state_reg == S_RDA) ? i_reg[lj_pkg::ADDR_BITS-1:0]
                                          : j_reg[lj_pkg::ADDR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && func == lj_pkg::FUNC_WRITE)
        begin
            pos_mem[particle_index] <= {pos_x, pos_y, pos_z};
        end
        rdata_reg <= pos_mem[rd_addr];
    end

    // Minimum-image fold of each axis, 2d compared against the box edge.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dd[k] = 25'(signed'(a_reg[(2-k)*CB +: CB])) - 25'(signed'(rdata_reg[(2-k)*CB +: CB]));
            if ((27'(dd[k]) <<< 1) >= signed'({4'd0, box_reg}))
            begin
                dfold[k] = 27'(dd[k]) - signed'({4'd0, box_reg});
            end
            else if ((27'(dd[k]) <<< 1) <= -signed'({4'd0, box_reg}))
            begin
                dfold[k] = 27'(dd[k]) + signed'({4'd0, box_reg});
            end
            else
            begin
                dfold[k] = 27'(dd[k]);
            end
            dmag[k] = dfold[k][26] ? 27'(-dfold[k]) : 27'(dfold[k]);
        end
    end

    always_comb
    begin
        mx = s_reg;
        my = s_reg;
        case (phase_reg)
            2'd1:
            begin
                mx = s2_reg;
                my = s_reg;
            end
            2'd2:
            begin
                mx = s3_reg;
                my = s3_reg;
            end
            default:
            begin
                mx = s_reg;
                my = s_reg;
            end
        endcase
        mul_a = 32'd0;
        mul_b = 32'd0;
        if (state_reg == S_SQ)
        begin
            if (step_reg < 3'd3)
            begin
                mul_a = {6'd0, dabs_reg[step_reg[1:0]]};
                mul_b = {6'd0, dabs_reg[step_reg[1:0]]};
            end
        end
        else
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = mx[31:0];
                    mul_b = my[31:0];
                end
                3'd1:
                begin
                    mul_a = mx[31:0];
                    mul_b = my[63:32];
                end
                3'd2:
                begin
                    mul_a = mx[63:32];
                    mul_b = my[31:0];
                end
                3'd3:
                begin
                    mul_a = mx[63:32];
                    mul_b = my[63:32];
                end
                default:
                begin
                    mul_a = 32'd0;
                    mul_b = 32'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        case (step_reg)
            3'd1:    pp_shift = {64'd0, mp_reg};
            3'd2:    pp_shift = {32'd0, mp_reg, 32'd0};
            3'd3:    pp_shift = {32'd0, mp_reg, 32'd0};
            default: pp_shift = {mp_reg, 64'd0};
        endcase
        macc_sum = macc_reg + pp_shift;
        div_trial = {rem_reg[31:0], (dcnt_reg == 6'(lj_pkg::DIV_BITS - 1))};
        r2_full   = sq_reg[53:16];
        pdiff     = s6_reg - s3_reg;
        ndiff     = {1'b0, s3_reg - s6_reg} + 65'h3FFF;
        tpos      = pdiff[63:14];
        tneg      = ndiff[64:14];
        add_sum   = 54'(acc_reg) + 54'(term_reg);
    end

    always_ff @(posedge clk)
    begin
        mp_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= lj_pkg::COUNT_RESET;
            box_reg <= lj_pkg::BOX_RESET;
            cut_reg <= lj_pkg::CUTOFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lj_pkg::CFG_COUNT:  cnt_reg <= cfg_data[NB-1:0];
                lj_pkg::CFG_BOX:    box_reg <= cfg_data[lj_pkg::BOX_BITS-1:0];
                lj_pkg::CFG_CUTOFF: cut_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            energy    <= '0;
            saturated <= 1'b0;
            func_reg  <= lj_pkg::FUNC_WRITE;
            i_reg     <= '0;
            j_reg     <= '0;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            step_reg  <= '0;
            phase_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg <= func;
                        acc_reg  <= '0;
                        sat_reg  <= 1'b0;
                        j_reg    <= '0;
                        if (func == lj_pkg::FUNC_PARTICLE)
                        begin
                            i_reg     <= NB'(particle_index);
                            state_reg <= S_NEXT;
                        end
                        else if (func == lj_pkg::FUNC_TOTAL)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_NEXT:
                begin
                    if (func_reg == lj_pkg::FUNC_PARTICLE)
                    begin
                        if (j_reg >= n_lim)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (j_reg == i_reg)
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_RDA;
                        end
                    end
                    else if (j_reg >= i_reg)
                    begin
                        if (10'(i_reg) + 10'd1 >= 10'(n_lim))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= '0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_RDA;
                    end
                end
                S_RDA:
                begin
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    a_reg     <= rdata_reg;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        dabs_reg[k] <= dmag[k][25:0];
                    end
                    sq_reg    <= '0;
                    step_reg  <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (step_reg != 3'd0)
                    begin
                        sq_reg <= sq_reg + 54'(mp_reg);
                    end
                    if (step_reg == 3'd3)
                    begin
                        state_reg <= S_CMP;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                S_CMP:
                begin
                    r2_reg <= (r2_full[37:32] != 6'd0) ? 32'hFFFF_FFFF : r2_full[31:0];
                    if (((r2_full[37:32] != 6'd0) ? 32'hFFFF_FFFF : r2_full[31:0]) >= cut_reg)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_NEXT;
                    end
                    else if (r2_full == 38'd0)
                    begin
                        term_reg     <= 53'(lj_pkg::E_MAX);
                        term_sat_reg <= 1'b1;
                        state_reg    <= S_ADD;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        dcnt_reg  <= 6'(lj_pkg::DIV_BITS - 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_trial >= {1'b0, r2_reg})
                    begin
                        rem_reg <= div_trial - {1'b0, r2_reg};
                        quo_reg <= {quo_reg[lj_pkg::DIV_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_trial;
                        quo_reg <= {quo_reg[lj_pkg::DIV_BITS-2:0], 1'b0};
                    end
                    if (dcnt_reg == 6'd0)
                    begin
                        phase_reg <= 2'd0;
                        step_reg  <= '0;
                        macc_reg  <= '0;
                        ov_reg    <= 1'b0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end
                    s_reg <= {15'd0, quo_reg[lj_pkg::DIV_BITS-2:0],
                              (div_trial >= {1'b0, r2_reg})};
                end
                S_MUL:
                begin
                    if (step_reg != 3'd0)
                    begin
                        macc_reg <= macc_sum;
                    end
                    if (step_reg == 3'd4)
                    begin
                        step_reg <= '0;
                        macc_reg <= '0;
                        if (macc_sum[127:96] != 32'd0)
                        begin
                            ov_reg <= 1'b1;
                        end
                        case (phase_reg)
                            2'd0:
                            begin
                                s2_reg <= (macc_sum[127:96] != 32'd0) ? '1 : macc_sum[95:32];
                            end
                            2'd1:
                            begin
                                s3_reg <= (macc_sum[127:96] != 32'd0) ? '1 : macc_sum[95:32];
                            end
                            default:
                            begin
                                s6_reg    <= (macc_sum[127:96] != 32'd0) ? '1 : macc_sum[95:32];
                                state_reg <= S_TERM;
                            end
                        endcase
                        phase_reg <= phase_reg + 1'b1;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_TERM:
                begin
                    if (ov_reg)
                    begin
                        term_reg     <= 53'(lj_pkg::E_MAX);
                        term_sat_reg <= 1'b1;
                    end
                    else if (s6_reg >= s3_reg)
                    begin
                        if (tpos[49:47] != 3'd0)
                        begin
                            term_reg     <= 53'(lj_pkg::E_MAX);
                            term_sat_reg <= 1'b1;
                        end
                        else
                        begin
                            term_reg     <= signed'({3'd0, tpos});
                            term_sat_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        term_reg     <= -signed'({2'd0, tneg});
                        term_sat_reg <= 1'b0;
                    end
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (add_sum > 54'(lj_pkg::E_MAX))
                    begin
                        acc_reg <= lj_pkg::E_MAX;
                        sat_reg <= 1'b1;
                    end
                    else if (add_sum < 54'(lj_pkg::E_MIN))
                    begin
                        acc_reg <= lj_pkg::E_MIN;
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_reg <= add_sum[lj_pkg::ENERGY_BITS-1:0];
                    end
                    if (term_sat_reg)
                    begin
                        sat_reg <= 1'b1;
                    end
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= S_NEXT;
                end
                S_DONE:
                begin
                    if (func_reg == lj_pkg::FUNC_PARTICLE || func_reg == lj_pkg::FUNC_TOTAL)
                    begin
                        done      <= 1'b1;
                        energy    <= acc_reg;
                        saturated <= sat_reg;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == lj_pkg::FUNC_PARTICLE || func == lj_pkg::FUNC_TOTAL)) |=> busy)
        else $error("query beat did not start the sequencer");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat lasted more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while the sequencer is still working");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == lj_pkg::FUNC_WRITE) |=> ##1 !done)
        else $error("write beat produced a result");

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {BEAT_OP, BEAT_CFG, BEAT_DRAIN} beat_kind_t;

    typedef struct {
        beat_kind_t                           kind;
        logic [1:0]                           func;
        logic [lj_pkg::ADDR_BITS-1:0]         idx;
        logic signed [lj_pkg::COORD_BITS-1:0] x;
        logic signed [lj_pkg::COORD_BITS-1:0] y;
        logic signed [lj_pkg::COORD_BITS-1:0] z;
        logic [lj_pkg::CFG_IDX_BITS-1:0]      reg_idx;
        logic [lj_pkg::CUT_BITS-1:0]          data;
    } beat_t;

    typedef struct {
        logic signed [lj_pkg::ENERGY_BITS-1:0] energy;
        logic                                  sat;
    } energy_t;

    localparam longint ENERGY_TOP = 64'sh7FFF_FFFF_FFFF;
    localparam longint ENERGY_BOT = -ENERGY_TOP - 1;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] func = lj_pkg::FUNC_WRITE;
    logic [lj_pkg::ADDR_BITS-1:0] particle_index = '0;
    logic signed [lj_pkg::COORD_BITS-1:0] pos_x = '0;
    logic signed [lj_pkg::COORD_BITS-1:0] pos_y = '0;
    logic signed [lj_pkg::COORD_BITS-1:0] pos_z = '0;
    logic cfg_we = 1'b0;
    logic [lj_pkg::CFG_IDX_BITS-1:0] cfg_index = lj_pkg::CFG_COUNT;
    logic [lj_pkg::CUT_BITS-1:0] cfg_data = '0;
    logic done;
    logic signed [lj_pkg::ENERGY_BITS-1:0] energy;
    logic saturated;

    lj_particle_energy_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .particle_index(particle_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .energy(energy), .saturated(saturated)
    );

    beat_t   pending_beats[$];
    energy_t energy_expected[$];
    int      errors = 0;

    logic signed [lj_pkg::COORD_BITS-1:0] model_pos[lj_pkg::MAX_PARTICLES][3];
    logic [lj_pkg::COUNT_BITS-1:0] model_count = lj_pkg::COUNT_RESET;
    logic [lj_pkg::BOX_BITS-1:0]   model_box = lj_pkg::BOX_RESET;
    logic [lj_pkg::CUT_BITS-1:0]   model_cutoff = lj_pkg::CUTOFF_RESET;
    logic                          sat_flag;

    function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:96] != 0)
        begin
            sat_flag = 1'b1;
            return '1;
        end
        return p[95:32];
    endfunction

    function automatic logic [31:0] image_r2(input int a, input int b);
        longint d;
        longint l;
        longint sum;
        l = longint'(model_box);
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = longint'(model_pos[a][k]) - longint'(model_pos[b][k]);
            if (2 * d >= l)
                d -= l;
            else if (2 * d <= -l)
                d += l;
            if (d >= (longint'(1) << 26) || d <= -(longint'(1) << 26))
                return '1;
            sum += d * d;
        end
        sum = sum >> 16;
        if (sum > 64'hFFFF_FFFF)
            return '1;
        return sum[31:0];
    endfunction

    function automatic longint lj_term(input logic [31:0] r2);
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] s3;
        logic [63:0] s6;
        logic [63:0] t;
        logic        ov_before;
        if (r2 == 0)
        begin
            sat_flag = 1'b1;
            return ENERGY_TOP;
        end
        ov_before = sat_flag;
        sat_flag = 1'b0;
        s = (64'd1 << 48) / {32'd0, r2};
        s2 = q32_mul(s, s);
        s3 = q32_mul(s2, s);
        s6 = q32_mul(s3, s3);
        if (sat_flag)
            return ENERGY_TOP;
        sat_flag = ov_before;
        if (s6 >= s3)
        begin
            t = (s6 - s3) >> 14;
            if (t > 64'h7FFF_FFFF_FFFF)
            begin
                sat_flag = 1'b1;
                return ENERGY_TOP;
            end
            return longint'(t);
        end
        t = ((s3 - s6) + 64'h3FFF) >> 14;
        return -longint'(t);
    endfunction

    function automatic longint add_pair(input int a, input int b, input longint acc);
        logic [31:0] r2;
        longint      r;
        r2 = image_r2(a, b);
        if (r2 >= model_cutoff)
            return acc;
        r = acc + lj_term(r2);
        if (r > ENERGY_TOP)
        begin
            sat_flag = 1'b1;
            return ENERGY_TOP;
        end
        if (r < ENERGY_BOT)
        begin
            sat_flag = 1'b1;
            return ENERGY_BOT;
        end
        return r;
    endfunction

    function automatic energy_t predict_energy(input beat_t b);
        int      n;
        longint  acc;
        energy_t e;
        n = (model_count > lj_pkg::MAX_PARTICLES) ? lj_pkg::MAX_PARTICLES : int'(model_count);
        acc = 0;
        sat_flag = 1'b0;
        if (b.func == lj_pkg::FUNC_PARTICLE)
        begin
            for (int j = 0; j < n; j++)
                if (j != int'(b.idx))
                    acc = add_pair(int'(b.idx), j, acc);
        end
        else
        begin
            for (int i = 0; i < n; i++)
                for (int j = 0; j < i; j++)
                    acc = add_pair(i, j, acc);
        end
        e.energy = acc[47:0];
        e.sat = sat_flag;
        return e;
    endfunction

    function automatic void accept_beat(input beat_t b);
        if (b.func == lj_pkg::FUNC_WRITE)
        begin
            model_pos[b.idx][0] = b.x;
            model_pos[b.idx][1] = b.y;
            model_pos[b.idx][2] = b.z;
        end
        else if (b.func == lj_pkg::FUNC_PARTICLE || b.func == lj_pkg::FUNC_TOTAL)
            energy_expected.push_back(predict_energy(b));
    endfunction

    function automatic void apply_register(input beat_t b);
        case (b.reg_idx)
            lj_pkg::CFG_COUNT:  model_count = b.data[lj_pkg::COUNT_BITS-1:0];
            lj_pkg::CFG_BOX:    model_box = b.data[lj_pkg::BOX_BITS-1:0];
            lj_pkg::CFG_CUTOFF: model_cutoff = b.data;
            default:    ;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    beat_t cur_beat;
    int    hold_cycles = 0;
    int    settle_cycles = 0;

    always @(posedge clk or negedge rst_n)
    begin
        bit    go;
        bit    we;
        beat_t nb;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
            hold_cycles = 0;
            settle_cycles = 0;
        end
        else
        begin
            go = start;
            we = 1'b0;
            if (start && !busy)
            begin
                accept_beat(cur_beat);
                go = 1'b0;
                hold_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            end
            if (!busy && !start && energy_expected.size() == 0)
                settle_cycles++;
            else
                settle_cycles = 0;
            if (!go && hold_cycles > 0)
                hold_cycles--;
            else if (!go && pending_beats.size() > 0)
            begin
                nb = pending_beats[0];
                if (nb.kind == BEAT_OP)
                begin
                    void'(pending_beats.pop_front());
                    cur_beat = nb;
                    func <= nb.func;
                    particle_index <= nb.idx;
                    pos_x <= nb.x;
                    pos_y <= nb.y;
                    pos_z <= nb.z;
                    go = 1'b1;
                end
                else if (settle_cycles >= 8)
                begin
                    void'(pending_beats.pop_front());
                    settle_cycles = 0;
                    if (nb.kind == BEAT_CFG)
                    begin
                        we = 1'b1;
                        cfg_index <= nb.reg_idx;
                        cfg_data <= nb.data;
                        apply_register(nb);
                    end
                end
            end
            start <= go;
            cfg_we <= we;
        end
    end

    always @(posedge clk)
    begin
        energy_t e;
        if (rst_n && done)
        begin
            if (energy_expected.size() == 0)
            begin
                $display("%0t: result with none expected, energy %0d saturated %0d",
                         $time, energy, saturated);
                errors++;
            end
            else
            begin
                e = energy_expected.pop_front();
                if (energy !== e.energy)
                begin
                    $display("%0t: energy expected %0d actual %0d", $time, e.energy, energy);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $display("%0t: saturated expected %0d actual %0d", $time, e.sat,
                             saturated);
                    errors++;
                end
            end
        end
    end

    int                            stim_ops = 0;
    logic [lj_pkg::BOX_BITS-1:0]   stim_box = lj_pkg::BOX_RESET;
    logic [lj_pkg::COUNT_BITS-1:0] stim_count = lj_pkg::COUNT_RESET;

    task automatic add_op(input logic [1:0] f, input int idx, input logic signed [23:0] x,
                          input logic signed [23:0] y, input logic signed [23:0] z);
        beat_t b;
        b.kind = BEAT_OP;
        b.func = f;
        b.idx = idx[lj_pkg::ADDR_BITS-1:0];
        b.x = x;
        b.y = y;
        b.z = z;
        b.reg_idx = lj_pkg::CFG_COUNT;
        b.data = '0;
        pending_beats.push_back(b);
        if (f != FUNC_UNUSED)
            stim_ops++;
    endtask

    task automatic add_cfg(input logic [lj_pkg::CFG_IDX_BITS-1:0] r, input logic [31:0] data);
        beat_t b;
        b = '{kind: BEAT_CFG, func: lj_pkg::FUNC_WRITE, idx: '0, x: '0, y: '0, z: '0,
              reg_idx: r, data: data};
        pending_beats.push_back(b);
        if (r == lj_pkg::CFG_BOX)
            stim_box = data[lj_pkg::BOX_BITS-1:0];
        if (r == lj_pkg::CFG_COUNT)
            stim_count = data[lj_pkg::COUNT_BITS-1:0];
    endtask

    task automatic add_drain();
        beat_t b;
        b = '{kind: BEAT_DRAIN, func: lj_pkg::FUNC_WRITE, idx: '0, x: '0, y: '0, z: '0,
              reg_idx: lj_pkg::CFG_COUNT, data: '0};
        pending_beats.push_back(b);
    endtask

    function automatic logic signed [23:0] box_coord();
        if (stim_box < 2)
            return '0;
        return 24'($urandom_range(0, stim_box - 1));
    endfunction

    task automatic add_write_in_box(input int idx);
        add_op(lj_pkg::FUNC_WRITE, idx, box_coord(), box_coord(), box_coord());
    endtask

    initial
    begin
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        int                 r;
        int                 phase_len;

        add_cfg(lj_pkg::CFG_BOX, 32'd262144);
        for (int i = 0; i < lj_pkg::MAX_PARTICLES; i++)
            add_write_in_box(i);

        add_cfg(lj_pkg::CFG_COUNT, 32'd4);
        add_cfg(lj_pkg::CFG_CUTOFF, 32'd9 << 16);
        add_op(lj_pkg::FUNC_WRITE, 0, 24'sh7FFFFF, -24'sd8388608, 24'sh7FFFFF);
        add_op(lj_pkg::FUNC_PARTICLE, 0, '0, '0, '0);
        add_op(lj_pkg::FUNC_TOTAL, 0, '0, '0, '0);
        add_write_in_box(0);
        px = box_coord();
        py = box_coord();
        pz = box_coord();
        add_op(lj_pkg::FUNC_WRITE, 2, px, py, pz);
        add_op(lj_pkg::FUNC_WRITE, 3, px, py, pz);
        add_op(lj_pkg::FUNC_PARTICLE, 2, '0, '0, '0);
        add_op(lj_pkg::FUNC_PARTICLE, 255, '0, '0, '0);
        add_op(FUNC_UNUSED, 1, '1, '1, '1);
        add_op(lj_pkg::FUNC_TOTAL, 0, '0, '0, '0);
        add_cfg(lj_pkg::CFG_COUNT, 32'd0);
        add_op(lj_pkg::FUNC_PARTICLE, 1, '0, '0, '0);
        add_op(lj_pkg::FUNC_TOTAL, 0, '0, '0, '0);
        add_cfg(lj_pkg::CFG_COUNT, 32'd5);
        add_cfg(lj_pkg::CFG_BOX, 32'd0);
        add_op(lj_pkg::FUNC_TOTAL, 0, '0, '0, '0);
        add_cfg(lj_pkg::CFG_BOX, 32'd8388607);
        add_cfg(lj_pkg::CFG_CUTOFF, 32'hFFFF_FFFF);
        add_op(lj_pkg::FUNC_TOTAL, 0, '0, '0, '0);
        add_cfg(lj_pkg::CFG_CUTOFF, 32'd0);
        add_op(lj_pkg::FUNC_PARTICLE, 1, '0, '0, '0);
        add_cfg(lj_pkg::CFG_BOX, 32'd262144);
        add_cfg(lj_pkg::CFG_CUTOFF, 32'd9 << 16);
        add_cfg(lj_pkg::CFG_COUNT, 32'd256);
        add_op(lj_pkg::FUNC_PARTICLE, 7, '0, '0, '0);
        add_cfg(lj_pkg::CFG_COUNT, 32'd300);
        add_op(lj_pkg::FUNC_PARTICLE, 3, '0, '0, '0);
        add_cfg(lj_pkg::CFG_CUTOFF, 32'd0);
        add_op(lj_pkg::FUNC_TOTAL, 0, '0, '0, '0);

        while (stim_ops < 1800)
        begin
            add_cfg(lj_pkg::CFG_COUNT, ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                                    : $urandom_range(2, 10));
            if ($urandom_range(0, 5) == 0)
                add_cfg(lj_pkg::CFG_BOX, $urandom_range(1, 8388607));
            else
                add_cfg(lj_pkg::CFG_BOX, $urandom_range(2 << 16, 8 << 16));
            if ($urandom_range(0, 5) == 0)
                add_cfg(lj_pkg::CFG_CUTOFF, $urandom());
            else
                add_cfg(lj_pkg::CFG_CUTOFF, $urandom_range(1 << 16, 16 << 16));
            phase_len = $urandom_range(30, 50);
            for (int k = 0; k < phase_len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    if ($urandom_range(0, 7) == 0)
                        add_op(lj_pkg::FUNC_WRITE, $urandom_range(0, 255), 24'($urandom()),
                               24'($urandom()), 24'($urandom()));
                    else
                        add_write_in_box($urandom_range(0, 255));
                end
                else if (r < 88 || (r < 94 && stim_count > 10))
                    add_op(lj_pkg::FUNC_PARTICLE, $urandom_range(0, 255), 24'($urandom()),
                           24'($urandom()), 24'($urandom()));
                else if (r < 94)
                    add_op(lj_pkg::FUNC_TOTAL, $urandom_range(0, 255), 24'($urandom()),
                           24'($urandom()), 24'($urandom()));
                else if (r < 97)
                    add_op(FUNC_UNUSED, $urandom_range(0, 255), 24'($urandom()),
                           24'($urandom()), 24'($urandom()));
                else
                    add_drain();
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_beats.size() != 0 || start || energy_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/lj_pkg.sv
hw/rtl/lj_particle_energy_unit.sv
dv/tb.sv
